// File: rtl/wtsq_pkg.sv
package wtsq_pkg;

    // Operation codes on the func field
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WALK_WAIT,
        ST_WALK_TEST,
        ST_FIX_NEW,
        ST_FIX_PREV,
        ST_POP_WAIT,
        ST_POP_LOAD,
        ST_FINISH
    } wtsq_state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic latch;      // capture the accepted item
        logic ins_empty;  // insert into an empty list
        logic ins_front;  // insert before the head
        logic ins_back;   // insert after the tail
        logic ins_mid;    // commit the slot and start the walk at the head
        logic walk_adv;   // step the walk cursor to its successor
        logic fix_new;    // link the new slot to the cursor's successor
        logic fix_prev;   // link the cursor to the new slot
        logic pop;        // take the head off the list
        logic pop_load;   // make the old head's successor the head
        logic load_out;   // load the result register
    } wtsq_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic is_pop;       // latched item is a remove
        logic reject;       // insert is ignored
        logic empty;        // no slot queued
        logic multi;        // more than one slot queued
        logic before_head;  // new tick is earlier than the head tick
        logic after_tail;   // new tick is equal to or later than the tail tick
        logic walk_go;      // cursor is not the tail and its successor does not wake later
    } wtsq_status_t;

endpackage

// File: rtl/wtsq_ram.sv
module wtsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/wtsq_ctrl.sv
module wtsq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  wtsq_pkg::wtsq_status_t status,
    output wtsq_pkg::wtsq_cmd_t    cmd
);

    wtsq_pkg::wtsq_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wtsq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != wtsq_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            wtsq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = wtsq_pkg::ST_DECIDE;
                end
            end
            wtsq_pkg::ST_DECIDE:
            begin
                state_next = wtsq_pkg::ST_FINISH;
                if (status.is_pop)
                begin
                    if (!status.empty)
                    begin
                        cmd.pop = 1'b1;
                        if (status.multi)
                        begin
                            state_next = wtsq_pkg::ST_POP_WAIT;
                        end
                    end
                end
                else
                begin
                    priority if (status.reject)
                    begin
                        state_next = wtsq_pkg::ST_FINISH;
                    end
                    else if (status.empty)
                    begin
                        cmd.ins_empty = 1'b1;
                    end
                    else if (status.before_head)
                    begin
                        cmd.ins_front = 1'b1;
                    end
                    else if (status.after_tail)
                    begin
                        cmd.ins_back = 1'b1;
                    end
                    else
                    begin
                        cmd.ins_mid = 1'b1;
                        state_next  = wtsq_pkg::ST_WALK_WAIT;
                    end
                end
            end
            wtsq_pkg::ST_WALK_WAIT:
            begin
                state_next = wtsq_pkg::ST_WALK_TEST;
            end
            wtsq_pkg::ST_WALK_TEST:
            begin
                if (status.walk_go)
                begin
                    cmd.walk_adv = 1'b1;
                    state_next   = wtsq_pkg::ST_WALK_WAIT;
                end
                else
                begin
                    cmd.fix_new = 1'b1;
                    state_next  = wtsq_pkg::ST_FIX_PREV;
                end
            end
            wtsq_pkg::ST_FIX_NEW:
            begin
                cmd.fix_new = 1'b1;
                state_next  = wtsq_pkg::ST_FIX_PREV;
            end
            wtsq_pkg::ST_FIX_PREV:
            begin
                cmd.fix_prev = 1'b1;
                state_next   = wtsq_pkg::ST_FINISH;
            end
            wtsq_pkg::ST_POP_WAIT:
            begin
                state_next = wtsq_pkg::ST_POP_LOAD;
            end
            wtsq_pkg::ST_POP_LOAD:
            begin
                cmd.pop_load = 1'b1;
                state_next   = wtsq_pkg::ST_FINISH;
            end
            wtsq_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = wtsq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wtsq_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the result until its transfer, set it on load
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Result register is never overwritten before its transfer
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending result");

    // An accepted item goes straight to the decision step
    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == wtsq_pkg::ST_DECIDE))
        else $error("accepted item did not reach decision");

    // A walk step always follows a wait for the successor tick
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wtsq_pkg::ST_WALK_TEST) |->
            ($past(state_reg) == wtsq_pkg::ST_WALK_WAIT))
        else $error("walk test without tick read");

endmodule

// File: rtl/wtsq_datapath.sv
module wtsq_datapath #(
    parameter int SLOTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   func,
    input  logic [3:0]             slot_id,
    input  logic [31:0]            wake_tick,
    input  wtsq_pkg::wtsq_cmd_t    cmd,
    output wtsq_pkg::wtsq_status_t status,
    output logic                   queue_empty,
    output logic [3:0]             head_slot,
    output logic [31:0]            head_tick,
    output logic [4:0]             entry_count,
    output logic                   pop_valid,
    output logic [3:0]             popped_slot
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Latched item
    logic             func_reg;
    logic [3:0]       id_reg;
    logic [31:0]      tick_reg;

    // List state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [31:0]      head_tick_reg, head_tick_next;
    logic [31:0]      tail_tick_reg, tail_tick_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [SLOTS-1:0] queued_reg, queued_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             pop_hit_reg, pop_hit_next;
    logic [IDX_W-1:0] popped_reg, popped_next;

    // Result register
    logic             queue_empty_reg;
    logic [3:0]       head_slot_reg;
    logic [31:0]      head_tick_out_reg;
    logic [4:0]       entry_count_reg;
    logic             pop_valid_reg;
    logic [3:0]       popped_slot_reg;

    // Memory ports
    logic [IDX_W-1:0] id_idx;
    logic             commit;
    logic             link_we;
    logic [IDX_W-1:0] link_waddr;
    logic [IDX_W-1:0] link_wdata;
    logic [IDX_W-1:0] link_q;
    logic [31:0]      tick_q;

    assign id_idx = IDX_W'(id_reg);
    assign commit = cmd.ins_empty | cmd.ins_front | cmd.ins_back | cmd.ins_mid;

    // Link table: read follows the cursor so data arrives with it
    wtsq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_next),
        .rdata (link_q)
    );

    // Tick table: read the successor named by the link output
    wtsq_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_tick_ram (
        .clk   (clk),
        .we    (commit),
        .waddr (id_idx),
        .wdata (tick_reg),
        .raddr (link_q),
        .rdata (tick_q)
    );

    // Select the link write
    always_comb
    begin
        link_we    = cmd.ins_front | cmd.ins_back | cmd.fix_new | cmd.fix_prev;
        link_waddr = id_idx;
        link_wdata = id_idx;
        priority if (cmd.ins_front)
        begin
            link_wdata = head_reg;
        end
        else if (cmd.ins_back)
        begin
            link_waddr = tail_reg;
        end
        else if (cmd.fix_new)
        begin
            link_wdata = link_q;
        end
        else if (cmd.fix_prev)
        begin
            link_waddr = cur_reg;
        end
        else
        begin
            link_wdata = id_idx;
        end
    end

    // Status toward the sequencer
    always_comb
    begin
        status.is_pop      = (func_reg == wtsq_pkg::FUNC_REMOVE);
        status.reject      = (int'(id_reg) >= SLOTS) || queued_reg[id_idx] ||
                             (count_reg == CNT_W'(SLOTS));
        status.empty       = (count_reg == '0);
        status.multi       = (count_reg > CNT_W'(1));
        status.before_head = (tick_reg < head_tick_reg);
        status.after_tail  = (tail_tick_reg <= tick_reg);
        status.walk_go     = (cur_reg != tail_reg) && (tick_q <= tick_reg);
    end

    // Next list state
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        head_tick_next = head_tick_reg;
        tail_tick_next = tail_tick_reg;
        count_next     = count_reg;
        queued_next    = queued_reg;
        cur_next       = cur_reg;
        pop_hit_next   = pop_hit_reg;
        popped_next    = popped_reg;

        if (cmd.latch)
        begin
            pop_hit_next = 1'b0;
        end
        if (commit)
        begin
            count_next          = count_reg + CNT_W'(1);
            queued_next[id_idx] = 1'b1;
        end
        if (cmd.ins_empty)
        begin
            head_next      = id_idx;
            tail_next      = id_idx;
            head_tick_next = tick_reg;
            tail_tick_next = tick_reg;
        end
        if (cmd.ins_front)
        begin
            head_next      = id_idx;
            head_tick_next = tick_reg;
        end
        if (cmd.ins_back)
        begin
            tail_next      = id_idx;
            tail_tick_next = tick_reg;
        end
        if (cmd.ins_mid)
        begin
            cur_next = head_reg;
        end
        if (cmd.walk_adv)
        begin
            cur_next = link_q;
        end
        if (cmd.pop)
        begin
            cur_next              = head_reg;
            popped_next           = head_reg;
            pop_hit_next          = 1'b1;
            count_next            = count_reg - CNT_W'(1);
            queued_next[head_reg] = 1'b0;
        end
        if (cmd.pop_load)
        begin
            head_next      = link_q;
            head_tick_next = tick_q;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            queued_reg  <= '0;
            pop_hit_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            queued_reg  <= queued_next;
            pop_hit_reg <= pop_hit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= func;
            id_reg   <= slot_id;
            tick_reg <= wake_tick;
        end
        head_tick_reg <= head_tick_next;
        tail_tick_reg <= tail_tick_next;
        cur_reg       <= cur_next;
        popped_reg    <= popped_next;
        if (cmd.load_out)
        begin
            queue_empty_reg   <= status.empty;
            head_slot_reg     <= status.empty ? 4'd0 : 4'(head_reg);
            head_tick_out_reg <= status.empty ? 32'd0 : head_tick_reg;
            entry_count_reg   <= 5'(count_reg);
            pop_valid_reg     <= pop_hit_reg;
            popped_slot_reg   <= pop_hit_reg ? 4'(popped_reg) : 4'd0;
        end
    end

    assign queue_empty = queue_empty_reg;
    assign head_slot   = head_slot_reg;
    assign head_tick   = head_tick_out_reg;
    assign entry_count = entry_count_reg;
    assign pop_valid   = pop_valid_reg;
    assign popped_slot = popped_slot_reg;

    // Occupancy bits agree with the count
    a_count_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == int'(count_reg))
        else $error("occupancy bits disagree with count");

    // A non-empty list has a queued head and tail once the operation is done
    a_ends_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && (count_reg != '0)) |->
            (queued_reg[head_reg] && queued_reg[tail_reg]))
        else $error("list end is not queued");

    // Head tick never exceeds tail tick
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (head_tick_reg <= tail_tick_reg))
        else $error("head wakes after tail");

endmodule

// File: rtl/wake_time_sorted_queue.sv
// Steps: a remove or an insert at either end is decided and then loads its result; a remove
// that leaves a new head first waits for and loads the successor tick; an ordered insert walks
// the list link by link (at most SLOTS-3 links), paced by the link/tick table reads, then links in.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: asynchronous, active low; clears the list to empty with no pending result.
module wake_time_sorted_queue #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [3:0]  slot_id,
    input  logic [31:0] wake_tick,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        queue_empty,
    output logic [3:0]  head_slot,
    output logic [31:0] head_tick,
    output logic [4:0]  entry_count,
    output logic        pop_valid,
    output logic [3:0]  popped_slot
);

    wtsq_pkg::wtsq_cmd_t    cmd;
    wtsq_pkg::wtsq_status_t status;

    // Sequencer
    wtsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // List tables and result register
    wtsq_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .func        (func),
        .slot_id     (slot_id),
        .wake_tick   (wake_tick),
        .cmd         (cmd),
        .status      (status),
        .queue_empty (queue_empty),
        .head_slot   (head_slot),
        .head_tick   (head_tick),
        .entry_count (entry_count),
        .pop_valid   (pop_valid),
        .popped_slot (popped_slot)
    );

endmodule

// File: bench/tb_wake_time_sorted_queue.sv
module tb_wake_time_sorted_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int DRAIN_WAIT = 40;   // margin for stray results, sized to outlast the longest ordered insert

    // One queue view as the block reports it after an operation
    typedef struct {
        logic        queue_empty;
        logic [3:0]  head_slot;
        logic [31:0] head_tick;
        logic [4:0]  entry_count;
        logic        pop_valid;
        logic [3:0]  popped_slot;
    } view_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [3:0]  slot_id;
    logic [31:0] wake_tick;
    logic        out_valid;
    logic        out_stall;
    logic        queue_empty;
    logic [3:0]  head_slot;
    logic [31:0] head_tick;
    logic [4:0]  entry_count;
    logic        pop_valid;
    logic [3:0]  popped_slot;

    // Shadow copy of the linked list
    logic [3:0]  lk_next   [SLOTS];
    logic [31:0] lk_tick   [SLOTS];
    logic        lk_queued [SLOTS];
    logic [3:0]  lk_head;
    logic [3:0]  lk_tail;
    int          lk_count;

    view_t       expected_views [$];
    view_t       oldest_view;
    int          mismatch_count;
    int          no_gap_left;
    int          stall_left;

    wake_time_sorted_queue #(
        .SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .slot_id(slot_id),
        .wake_tick(wake_tick),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .queue_empty(queue_empty),
        .head_slot(head_slot),
        .head_tick(head_tick),
        .entry_count(entry_count),
        .pop_valid(pop_valid),
        .popped_slot(popped_slot)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one operation to the shadow list and return the view after it
    function automatic view_t predict_view(input logic op, input logic [3:0] id,
                                           input logic [31:0] tick);
        view_t      v;
        logic [3:0] cur;
        int         steps;
        logic [3:0] h;
        v.pop_valid   = 1'b0;
        v.popped_slot = 4'd0;
        if (op == wtsq_pkg::FUNC_INSERT)
        begin
            if (!lk_queued[id] && lk_count < SLOTS)
            begin
                lk_tick[id]   = tick;
                lk_queued[id] = 1'b1;
                if (lk_count == 0)
                begin
                    lk_head     = id;
                    lk_tail     = id;
                    lk_next[id] = 4'd0;
                end
                else if (lk_tick[lk_head] > tick)
                begin
                    lk_next[id] = lk_head;
                    lk_head     = id;
                end
                else if (lk_tick[lk_tail] <= tick)
                begin
                    lk_next[lk_tail] = id;
                    lk_tail          = id;
                    lk_next[id]      = 4'd0;
                end
                else
                begin
                    // walk to the last entry that does not wake later
                    cur   = lk_head;
                    steps = 0;
                    while (steps < SLOTS && cur != lk_tail && lk_tick[lk_next[cur]] <= tick)
                    begin
                        cur = lk_next[cur];
                        steps++;
                    end
                    lk_next[id]  = lk_next[cur];
                    lk_next[cur] = id;
                end
                lk_count++;
            end
        end
        else if (lk_count > 0)
        begin
            h             = lk_head;
            v.pop_valid   = 1'b1;
            v.popped_slot = h;
            lk_queued[h]  = 1'b0;
            if (lk_count > 1)
                lk_head = lk_next[h];
            lk_count--;
        end
        if (lk_count == 0)
        begin
            v.queue_empty = 1'b1;
            v.head_slot   = 4'd0;
            v.head_tick   = 32'd0;
        end
        else
        begin
            v.queue_empty = 1'b0;
            v.head_slot   = lk_head;
            v.head_tick   = lk_tick[lk_head];
        end
        v.entry_count = lk_count[4:0];
        return v;
    endfunction

    // Pick a free or a queued slot starting at a random position; 16 means none found
    function automatic int find_slot(input logic want_queued);
        int start;
        int i;
        int s;
        start = $urandom_range(0, SLOTS - 1);
        for (i = 0; i < SLOTS; i++)
        begin
            s = (start + i) % SLOTS;
            if (lk_queued[s] == want_queued)
                return s;
        end
        return SLOTS;
    endfunction

    // Wake tick mix: full range, tight range for ties, near a queued tick, extremes
    function automatic logic [31:0] make_tick();
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = find_slot(1'b1);
        if (r < 30)
            return $urandom;
        else if (r < 55)
            return $urandom_range(0, 7);
        else if (r < 85 && s < SLOTS)
            return lk_tick[s] + 32'($urandom_range(0, 2)) - 32'd1;
        else if (r < 92)
            return 32'd0;
        else
            return 32'hFFFF_FFFF;
    endfunction

    // Hold off the next transfer for a random number of cycles
    task automatic idle_gap();
        int n;
        int r;
        n = 0;
        if (no_gap_left > 0)
            no_gap_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                no_gap_left = $urandom_range(10, 40);
            else if (r < 75)
                n = $urandom_range(0, 2);
            else if (r < 95)
                n = $urandom_range(3, 8);
            else
                n = $urandom_range(10, 40);
        end
        if (n > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Present one item, wait for its transfer and record the expected view
    task automatic send_item(input logic op, input logic [3:0] id, input logic [31:0] tick);
        @(negedge clk);
        in_valid  <= 1'b1;
        func      <= op;
        slot_id   <= id;
        wake_tick <= tick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_views.push_back(predict_view(op, id, tick));
        idle_gap();
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result transfer with the oldest expected view
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_views.size() == 0)
            begin
                $display("%0t ns: result transfer with no expected view", $time);
                mismatch_count++;
            end
            else
            begin
                oldest_view = expected_views.pop_front();
                check_field("queue_empty", 32'(oldest_view.queue_empty), 32'(queue_empty));
                check_field("head_slot", 32'(oldest_view.head_slot), 32'(head_slot));
                check_field("head_tick", oldest_view.head_tick, head_tick);
                check_field("entry_count", 32'(oldest_view.entry_count), 32'(entry_count));
                check_field("pop_valid", 32'(oldest_view.pop_valid), 32'(pop_valid));
                check_field("popped_slot", 32'(oldest_view.popped_slot), 32'(popped_slot));
            end
        end
    end

    // Stall the result side in runs of random length
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    out_stall  <= 1'b1;
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                            : $urandom_range(10, 40);
                end
                else
                begin
                    out_stall  <= 1'b0;
                    stall_left = $urandom_range(0, 20);
                end
            end
            else
                stall_left--;
        end
    end

    // Both ends, ties at head, middle and tail, duplicates, remove on empty
    task automatic test_ends_and_ties();
        int i;
        send_item(wtsq_pkg::FUNC_REMOVE, 4'd0, 32'd0);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd5, 32'd100);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd15, 32'hFFFF_FFFF);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd3, 32'd100);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd7, 32'd50);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd0, 32'd0);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd9, 32'hFFFF_FFFF);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd5, 32'd1);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd12, 32'd200);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd10, 32'd100);
        send_item(wtsq_pkg::FUNC_INSERT, 4'd6, 32'h8000_0000);
        for (i = 0; i < 10; i++)
            send_item(wtsq_pkg::FUNC_REMOVE, 4'($urandom), $urandom);
    endtask

    // Fill every slot in random order, try one more, then drain past empty
    task automatic test_fill_and_drain();
        logic [3:0] order [SLOTS];
        logic [3:0] tmp;
        int         i;
        int         j;
        int         pass;
        for (pass = 0; pass < 2; pass++)
        begin
            for (i = 0; i < SLOTS; i++)
                order[i] = 4'(i);
            for (i = SLOTS - 1; i > 0; i--)
            begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (i = 0; i < SLOTS; i++)
                send_item(wtsq_pkg::FUNC_INSERT, order[i], make_tick());
            send_item(wtsq_pkg::FUNC_INSERT, 4'($urandom), $urandom);
            for (i = 0; i <= SLOTS; i++)
                send_item(wtsq_pkg::FUNC_REMOVE, 4'($urandom), $urandom);
        end
    endtask

    // Mostly legal traffic steered toward a moving fill level, with some noise
    task automatic test_random_mix(input int items);
        int k;
        int r;
        int s;
        int fill_goal;
        logic op;
        fill_goal = 8;
        for (k = 0; k < items; k++)
        begin
            if (k % 20 == 0)
            begin
                r = $urandom_range(0, 9);
                fill_goal = (r < 2) ? 0 : (r < 4) ? SLOTS : $urandom_range(1, SLOTS - 1);
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                send_item(wtsq_pkg::FUNC_INSERT, 4'($urandom), make_tick());
            else if (r < 8)
            begin
                s = find_slot(1'b1);
                if (s < SLOTS)
                    send_item(wtsq_pkg::FUNC_INSERT, 4'(s), make_tick());
                else
                    send_item(wtsq_pkg::FUNC_REMOVE, 4'($urandom), $urandom);
            end
            else
            begin
                if (lk_count == 0)
                    op = wtsq_pkg::FUNC_INSERT;
                else if (lk_count == SLOTS)
                    op = wtsq_pkg::FUNC_REMOVE;
                else if (lk_count < fill_goal)
                    op = ($urandom_range(0, 3) != 0) ? wtsq_pkg::FUNC_INSERT
                                                     : wtsq_pkg::FUNC_REMOVE;
                else if (lk_count > fill_goal)
                    op = ($urandom_range(0, 3) != 0) ? wtsq_pkg::FUNC_REMOVE
                                                     : wtsq_pkg::FUNC_INSERT;
                else
                    op = ($urandom_range(0, 1) != 0) ? wtsq_pkg::FUNC_INSERT
                                                     : wtsq_pkg::FUNC_REMOVE;
                if (op == wtsq_pkg::FUNC_INSERT)
                    send_item(wtsq_pkg::FUNC_INSERT, 4'(find_slot(1'b0)), make_tick());
                else
                    send_item(wtsq_pkg::FUNC_REMOVE, 4'($urandom), $urandom);
            end
        end
    endtask

    initial
    begin
        int i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = wtsq_pkg::FUNC_INSERT;
        slot_id        = 4'd0;
        wake_tick      = 32'd0;
        out_stall      = 1'b0;
        mismatch_count = 0;
        no_gap_left    = 0;
        stall_left     = 0;
        lk_head        = 4'd0;
        lk_tail        = 4'd0;
        lk_count       = 0;
        for (i = 0; i < SLOTS; i++)
        begin
            lk_next[i]   = 4'd0;
            lk_tick[i]   = 32'd0;
            lk_queued[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ends_and_ties();
        test_fill_and_drain();
        test_random_mix(330);

        // Drop valid, wait out the last results, then allow for strays
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_wake_time_sorted_queue: PASS");
        else
            $display("tb_wake_time_sorted_queue: FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("tb_wake_time_sorted_queue: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/wtsq_pkg.sv
rtl/wtsq_ram.sv
rtl/wtsq_ctrl.sv
rtl/wtsq_datapath.sv
rtl/wake_time_sorted_queue.sv
bench/tb_wake_time_sorted_queue.sv
